/* rtl/core/hdo_pkg.sv */
// Shared constants and field layout for the hysteresis debounce occupancy detector.
`timescale 1ns / 1ps

package hdo_pkg;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 12;

    // Fixed field widths
    localparam int CHAN_W   = 4;
    localparam int LEVEL_W  = 12;
    localparam int COUNT_W  = 8;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    // Input tdata layout, lowest bit first
    localparam int S_CHAN_LO = 0;
    localparam int S_SMP_LO  = S_CHAN_LO + CHAN_W;
    localparam int S_OCC_LO  = S_SMP_LO + LEVEL_W;
    localparam int S_REL_LO  = S_OCC_LO + LEVEL_W;

    // Debounce register reset value and saturation limit
    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

    // Request kinds carried on s_tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_SETUP  = 1'b1;

    // Per-channel run state: occupancy flag and match counter
    typedef struct packed {
        logic               occupied;
        logic [COUNT_W-1:0] count;
    } chan_state_t;

endpackage

/* rtl/core/hysteresis_debounce_occupancy.sv */
// An accepted sample request passes the input register stage, then the result register.
// Throughput: one request per cycle unless a result stalls; the state and threshold memories
// are read at accept and written on leaving the input stage, forwarding back-to-back writes.
// Set-up requests and requests to channels out of range produce no result.
// Reset (aresetn low, synchronous): all channels empty, counters zero, debounce count 5.
// Thresholds are not cleared by reset and must be written before a channel is sampled.
`timescale 1ns / 1ps

module hysteresis_debounce_occupancy
    import hdo_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: qualifying samples needed for a state change
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // channel[3:0], sample[15:4], occupy_level[27:16],
                                           // release_level[39:28]
    input  logic                s_tuser,   // func[0]
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // slot[3:0], occupied[4], changed[5],
                                           // match_run[13:6], zero[15:14]
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] occ;
        logic [SAMPLE_BITS-1:0] rel;
    } thr_t;

    // Debounce count register
    logic [COUNT_W-1:0] debounce_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_we) begin
            debounce_reg <= cfg_wdata;
        end
    end

    // Input field decode
    logic [CHAN_W-1:0]      in_chan;
    logic [31:0]            in_chan_wide;
    logic [31:0]            in_smp_wide;
    logic [31:0]            in_occ_wide;
    logic [31:0]            in_rel_wide;
    logic [IDX_W-1:0]       in_idx;
    logic                   in_range;
    logic                   s_acc;

    assign in_chan      = s_tdata[S_CHAN_LO +: CHAN_W];
    assign in_chan_wide = 32'(in_chan);
    assign in_smp_wide  = 32'(s_tdata[S_SMP_LO +: LEVEL_W]);
    assign in_occ_wide  = 32'(s_tdata[S_OCC_LO +: LEVEL_W]);
    assign in_rel_wide  = 32'(s_tdata[S_REL_LO +: LEVEL_W]);
    assign in_idx       = in_chan_wide[IDX_W-1:0];
    assign in_range     = (in_chan_wide < 32'(NUM_CHANNELS));
    assign s_acc        = s_tvalid && s_tready;

    // Input register stage
    logic                   s1_valid_reg;
    logic                   s1_func_reg;
    logic                   s1_range_reg;
    logic [CHAN_W-1:0]      s1_chan_reg;
    logic [SAMPLE_BITS-1:0] s1_smp_reg;
    logic [SAMPLE_BITS-1:0] s1_occ_reg;
    logic [SAMPLE_BITS-1:0] s1_rel_reg;
    logic [31:0]            s1_chan_wide;
    logic [IDX_W-1:0]       s1_idx;
    logic                   s1_result;
    logic                   advance;
    logic                   st_we;
    logic                   thr_we;

    assign s1_chan_wide = 32'(s1_chan_reg);
    assign s1_idx       = s1_chan_wide[IDX_W-1:0];
    assign s1_result    = s1_valid_reg && s1_range_reg && (s1_func_reg == FUNC_SAMPLE);
    assign advance      = s1_valid_reg && (!s1_result || !m_tvalid || m_tready);
    assign s_tready     = !s1_valid_reg || advance;
    assign st_we        = advance && s1_range_reg && (s1_func_reg == FUNC_SAMPLE);
    assign thr_we       = advance && s1_range_reg && (s1_func_reg == FUNC_SETUP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_func_reg  <= s_tuser;
            s1_range_reg <= in_range;
            s1_chan_reg  <= in_chan;
            s1_smp_reg   <= in_smp_wide[SAMPLE_BITS-1:0];
            s1_occ_reg   <= in_occ_wide[SAMPLE_BITS-1:0];
            s1_rel_reg   <= in_rel_wide[SAMPLE_BITS-1:0];
        end
    end

    // Threshold memory, write-first read at accept
    thr_t thr_mem [NUM_CHANNELS];
    thr_t thr_wdata;
    thr_t thr_rd_reg;

    assign thr_wdata = '{occ: s1_occ_reg, rel: s1_rel_reg};

    always_ff @(posedge aclk) begin
        if (thr_we) begin
            thr_mem[s1_idx] <= thr_wdata;
        end
        if (s_acc) begin
            if (thr_we && (s1_idx == in_idx)) begin
                thr_rd_reg <= thr_wdata;
            end else begin
                thr_rd_reg <= thr_mem[in_idx];
            end
        end
    end

    // Channel state memory with per-entry valid bits; an unwritten entry reads as empty
    chan_state_t            st_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] st_vld_reg;
    chan_state_t            st_wdata;
    chan_state_t            st_rd_reg;
    logic                   st_rd_vld_reg;
    logic                   st_fwd;

    assign st_fwd = st_we && (s1_idx == in_idx);

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[s1_idx] <= st_wdata;
        end
        if (s_acc) begin
            if (st_fwd) begin
                st_rd_reg <= st_wdata;
            end else begin
                st_rd_reg <= st_mem[in_idx];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg    <= '0;
            st_rd_vld_reg <= 1'b0;
        end else begin
            if (st_we) begin
                st_vld_reg[s1_idx] <= 1'b1;
            end
            if (s_acc) begin
                st_rd_vld_reg <= st_fwd || st_vld_reg[in_idx];
            end
        end
    end

    // Hysteresis compare and debounce update
    chan_state_t        cur;
    logic               inverted;
    logic               qualify;
    logic               flip;
    logic [COUNT_W-1:0] cnt_inc;

    always_comb begin
        cur      = st_rd_vld_reg ? st_rd_reg : '0;
        inverted = (thr_rd_reg.occ < thr_rd_reg.rel);
        if (!cur.occupied) begin
            qualify = inverted ? (s1_smp_reg <= thr_rd_reg.occ)
                               : (s1_smp_reg >= thr_rd_reg.occ);
        end else begin
            qualify = inverted ? (s1_smp_reg >= thr_rd_reg.rel)
                               : (s1_smp_reg <= thr_rd_reg.rel);
        end
        cnt_inc  = (cur.count == COUNT_MAX) ? cur.count : cur.count + 8'd1;
        flip     = qualify && (cnt_inc >= debounce_reg);
        st_wdata.occupied = cur.occupied ^ flip;
        st_wdata.count    = (qualify && !flip) ? cnt_inc : '0;
    end

    // Result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && s1_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_result) begin
            m_data_reg <= {2'b00, st_wdata.count, flip, st_wdata.occupied, s1_chan_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    a_flip_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[13:6] == '0)
        else $error("flip result with nonzero match count");

    a_state_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && st_fwd |=> st_rd_reg == $past(st_wdata) && st_rd_vld_reg)
        else $error("state forwarding lost a same-channel write");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_result && m_tvalid && !m_tready |-> !s_tready && !st_we)
        else $error("input stage advanced into a stalled result register");

    a_thr_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && thr_we && (s1_idx == in_idx) |=> thr_rd_reg == $past(thr_wdata))
        else $error("threshold forwarding lost a same-channel write");

endmodule
